// ----- rtl/core/fcull_pkg.sv -----
// Shared types and constants for the frustum cull block.
// Used by fcull_ctrl, fcull_dp and frustum_cull_point_sphere_box.
package fcull_pkg;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_POINT  = 2'd1;
  localparam logic [1:0] OP_SPHERE = 2'd2;
  localparam logic [1:0] OP_BOX    = 2'd3;

  localparam logic [1:0] COEF_A = 2'd0;
  localparam logic [1:0] COEF_B = 2'd1;
  localparam logic [1:0] COEF_C = 2'd2;
  localparam logic [1:0] COEF_D = 2'd3;

  localparam int PLANE_IDX_W = 3;
  // three Q32.32 products plus d and radius scaled to Q32.32 fit in 66 bits
  localparam int SUM_W = 66;
  localparam int IN_DATA_W = 264;
  localparam int OUT_DATA_W = 8;

  typedef struct packed {
    logic                   capture;
    logic                   wr_en;
    logic                   issue;
    logic                   last;
    logic [PLANE_IDX_W-1:0] plane;
  } dp_cmd_t;

  typedef struct packed {
    logic res_valid;
    logic res_last;
    logic reject;
  } dp_stat_t;

endpackage

// ----- rtl/core/fcull_dp.sv -----
// Datapath: plane coefficient store, query registers, six multipliers and
// the plane sum / reject test. Depends on fcull_pkg.
module fcull_dp #(
  parameter int NUM_PLANES = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fcull_pkg::dp_cmd_t cmd,
  input  logic [1:0]         in_op,
  input  logic [2:0]         in_plane,
  input  logic [1:0]         in_coeff_idx,
  input  logic signed [31:0] in_coeff,
  input  logic signed [31:0] in_x_lo,
  input  logic signed [31:0] in_y_lo,
  input  logic signed [31:0] in_z_lo,
  input  logic signed [31:0] in_x_hi,
  input  logic signed [31:0] in_y_hi,
  input  logic signed [31:0] in_z_hi,
  input  logic [30:0]        in_radius,
  output fcull_pkg::dp_stat_t stat
);
  import fcull_pkg::*;

  localparam int PW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

  logic signed [31:0] a_r [NUM_PLANES];
  logic signed [31:0] b_r [NUM_PLANES];
  logic signed [31:0] c_r [NUM_PLANES];
  logic signed [31:0] d_r [NUM_PLANES];

  logic [1:0]         op_r;
  logic signed [31:0] xl_r, yl_r, zl_r, xh_r, yh_r, zh_r;
  logic [30:0]        rad_r;

  logic [PW-1:0]      wr_idx;
  logic [PW-1:0]      rd_idx;
  logic signed [31:0] ca, cb, cc;

  logic signed [63:0] axl, axh, byl, byh, czl, czh;
  logic signed [63:0] axl_r, axh_r, byl_r, byh_r, czl_r, czh_r;
  logic signed [31:0] d1_r;
  logic               v1_r, l1_r;

  logic signed [63:0] tx, ty, tz;
  logic [SUM_W-1:0]   bias;
  logic [SUM_W-1:0]   sum_nxt;
  logic [SUM_W-1:0]   sum_r;
  logic               v2_r, l2_r;

  assign wr_idx = in_plane[PW-1:0];
  assign rd_idx = cmd.plane[PW-1:0];

  // coefficient store, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        a_r[i] <= '0;
        b_r[i] <= '0;
        c_r[i] <= '0;
        d_r[i] <= '0;
      end
    end else if (cmd.wr_en) begin
      case (in_coeff_idx)
        COEF_A:  a_r[wr_idx] <= in_coeff;
        COEF_B:  b_r[wr_idx] <= in_coeff;
        COEF_C:  c_r[wr_idx] <= in_coeff;
        COEF_D:  d_r[wr_idx] <= in_coeff;
        default: d_r[wr_idx] <= in_coeff;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_op;
      xl_r  <= in_x_lo;
      yl_r  <= in_y_lo;
      zl_r  <= in_z_lo;
      xh_r  <= in_x_hi;
      yh_r  <= in_y_hi;
      zh_r  <= in_z_hi;
      rad_r <= in_radius;
    end
  end

  // stage 1: six products for the selected plane
  assign ca  = a_r[rd_idx];
  assign cb  = b_r[rd_idx];
  assign cc  = c_r[rd_idx];
  assign axl = ca * xl_r;
  assign axh = ca * xh_r;
  assign byl = cb * yl_r;
  assign byh = cb * yh_r;
  assign czl = cc * zl_r;
  assign czh = cc * zh_r;

  always_ff @(posedge clk) begin
    axl_r <= axl;
    axh_r <= axh;
    byl_r <= byl;
    byh_r <= byh;
    czl_r <= czl;
    czh_r <= czh;
    d1_r  <= d_r[rd_idx];
    l1_r  <= cmd.last;
  end

  // stage 2: box keeps the largest term per axis, i.e. the most inside corner
  always_comb begin
    if (op_r == OP_BOX) begin
      tx = (axl_r > axh_r) ? axl_r : axh_r;
      ty = (byl_r > byh_r) ? byl_r : byh_r;
      tz = (czl_r > czh_r) ? czl_r : czh_r;
    end else begin
      tx = axl_r;
      ty = byl_r;
      tz = czl_r;
    end
    bias = (op_r == OP_SPHERE) ? {19'b0, rad_r, 16'b0} : '0;
    sum_nxt = {{2{tx[63]}}, tx} + {{2{ty[63]}}, ty} + {{2{tz[63]}}, tz}
            + {{18{d1_r[31]}}, d1_r, 16'b0} + bias;
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    l2_r  <= l1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
    end
  end

  assign stat.res_valid = v2_r;
  assign stat.res_last  = l2_r;
  assign stat.reject    = sum_r[SUM_W-1] | (sum_r == '0);

endmodule

// ----- rtl/core/fcull_ctrl.sv -----
// Controller: accepts words, sequences the planes through the datapath and
// holds the output register. Depends on fcull_pkg.
module fcull_ctrl #(
  parameter int NUM_PLANES = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [1:0]          in_op,
  input  logic [2:0]          in_plane,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic                out_inside,
  output fcull_pkg::dp_cmd_t  cmd,
  input  fcull_pkg::dp_stat_t stat
);
  import fcull_pkg::*;

  localparam int PW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam logic [PW-1:0] LAST_PLANE = PW'(NUM_PLANES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [PW-1:0] cnt_r, cnt_nxt;
  logic          inside_r, inside_nxt;
  logic          ovalid_r, ovalid_nxt;
  logic          oinside_r, oinside_nxt;
  logic          accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    inside_nxt  = inside_r;
    ovalid_nxt  = ovalid_r;
    oinside_nxt = oinside_r;
    cmd         = '0;

    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;

    if (stat.res_valid && stat.reject) inside_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          cnt_nxt     = '0;
          if (in_op == OP_LOAD) begin
            cmd.wr_en  = ({1'b0, in_plane} < 4'(NUM_PLANES));
            inside_nxt = 1'b0;
            state_nxt  = S_DONE;
          end else begin
            inside_nxt = 1'b1;
            state_nxt  = S_RUN;
          end
        end
      end
      S_RUN: begin
        cmd.issue = 1'b1;
        cmd.plane = PLANE_IDX_W'(cnt_r);
        cmd.last  = (cnt_r == LAST_PLANE);
        cnt_nxt   = cnt_r + PW'(1);
        if (cnt_r == LAST_PLANE) state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (stat.res_valid && stat.res_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt  = 1'b1;
          oinside_nxt = inside_r;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      inside_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      inside_r <= inside_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oinside_r <= oinside_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_inside = oinside_r;

endmodule

// ----- rtl/core/frustum_cull_point_sphere_box.sv -----
// Frustum cull of points, spheres and boxes against NUM_PLANES stored planes.
// Load word: writes one plane coefficient, result inside 0. Query word: planes in turn,
// one plane per cycle through a product stage and a sum stage, one word at a time;
// a new word is taken only once the last result has moved into the output register.
// Reset (rst_n, synchronous, active low) clears control state and zeroes all planes.
// Depends on fcull_pkg, fcull_ctrl and fcull_dp.
module frustum_cull_point_sphere_box #(
  parameter int NUM_PLANES = 6
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // operation
  input  logic [1:0]                       in_tuser,
  // plane_index, coeff_index, coeff_value, x_lo, y_lo, z_lo, x_hi, y_hi, z_hi,
  // radius, zero pad
  input  logic [fcull_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // inside_res, zero pad
  output logic [fcull_pkg::OUT_DATA_W-1:0] out_tdata
);
  import fcull_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     inside_res;

  fcull_ctrl #(.NUM_PLANES(NUM_PLANES)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .in_plane   (in_tdata[2:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_inside (inside_res),
    .cmd        (cmd),
    .stat       (stat)
  );

  fcull_dp #(.NUM_PLANES(NUM_PLANES)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_op        (in_tuser),
    .in_plane     (in_tdata[2:0]),
    .in_coeff_idx (in_tdata[4:3]),
    .in_coeff     (in_tdata[36:5]),
    .in_x_lo      (in_tdata[68:37]),
    .in_y_lo      (in_tdata[100:69]),
    .in_z_lo      (in_tdata[132:101]),
    .in_x_hi      (in_tdata[164:133]),
    .in_y_hi      (in_tdata[196:165]),
    .in_z_hi      (in_tdata[228:197]),
    .in_radius    (in_tdata[259:229]),
    .stat         (stat)
  );

  assign out_tdata = {{(OUT_DATA_W-1){1'b0}}, inside_res};

`ifndef SYNTHESIS
  a_no_write_during_issue: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_en && cmd.issue))
    else $error("plane store written while planes are being issued");

  a_busy_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    stat.res_valid |-> !in_tready)
    else $error("input ready while a plane result is in flight");

  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second word accepted before the first finished");
`endif

endmodule
